### sv/alwl_pkg.sv
package alwl_pkg;

   // Number of elements the list can hold.
   localparam int unsigned CAPACITY = 1024;
   // Address width of the element store.
   localparam int unsigned ADDR_W   = $clog2(CAPACITY);
   // Width of the length and cursor fields; they count 0..CAPACITY.
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned POS_W    = 10;
   localparam int unsigned CMD_W    = 4;
   localparam int unsigned STAT_W   = 2;

   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 56;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 4'd0,
      CMD_REMOVE = 4'd1,
      CMD_APPEND = 4'd2,
      CMD_PREV   = 4'd3,
      CMD_NEXT   = 4'd4,
      CMD_START  = 4'd5,
      CMD_END    = 4'd6,
      CMD_GOTO   = 4'd7,
      CMD_CLEAR  = 4'd8
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_NOELEM = 2'd2,
      STAT_RANGE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SHIFT_UP,
      ST_SHIFT_DN,
      ST_LOOKUP,
      ST_DONE
   } state_type;

endpackage

### sv/array_list_with_cursor.sv
// Channel  Direction  Handshake            Payload (lowest bit first)
// req      in         req_tvalid/tready    cmd[3:0] value[35:4] position[45:36]
// rsp      out        rsp_tvalid/tready    status[1:0] data[33:2] length[44:34]
//                                          cursor[55:45]
//
// One request is worked on at a time. Cursor moves, append, clear and failed
// commands pass through the decode, lookup and done states before their result
// is registered, and the next request is taken in the idle state. Insert and
// remove move one element per cycle through the element memory; insert then
// goes through lookup and done, while remove goes straight to done.
// Reset clears length and cursor, not the element store; no request is taken in reset.
// A new request is accepted while an earlier result still waits in the
// output register; the new result then waits until that one is taken.
module array_list_with_cursor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cmd[3:0], value[35:4], position[45:36], zero fill above
   input  logic [alwl_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], data[33:2], length[44:34], cursor[55:45]
   output logic [alwl_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   import alwl_pkg::*;

   // Sequencer state and list bookkeeping.
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   len_ff, len_in;
   logic [COUNT_W-1:0]   cur_ff, cur_in;

   // The request being worked on.
   cmd_type              cmd_ff, cmd_in;
   logic [DATA_W-1:0]    val_ff, val_in;
   logic [POS_W-1:0]     pos_ff, pos_in;

   // Shift engine: reads run ahead, each read's data is written in the cycle after.
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    src_ff, src_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_addr_ff, pend_addr_in;

   // Result assembly.
   status_type           status_ff, status_in;
   logic [DATA_W-1:0]    cap_ff, cap_in;
   logic                 use_cap_ff, use_cap_in;
   logic                 hit_ff, hit_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory port signals.
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [DATA_W-1:0]    ram_wdata;
   logic                 ram_re;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [DATA_W-1:0]    ram_rdata;

   logic                 full;
   logic                 rsp_free;
   logic [DATA_W-1:0]    result_data;

   alwl_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign full       = (len_ff >= COUNT_W'(CAPACITY));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A successful remove returns the captured element; everything else reports
   // the element under the cursor, or zero when the cursor is past the end.
   assign result_data = use_cap_ff ? cap_ff : (hit_ff ? ram_rdata : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      cnt_ff       <= cnt_in;
      src_ff       <= src_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      cap_ff       <= cap_in;
      use_cap_ff   <= use_cap_in;
      hit_ff       <= hit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      status_in    = status_ff;
      cap_in       = cap_ff;
      use_cap_in   = use_cap_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      ram_we    = 1'b0;
      ram_waddr = len_ff[ADDR_W-1:0];
      ram_wdata = val_ff;
      ram_re    = 1'b0;
      ram_raddr = cur_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tdata[CMD_W-1:0]);
               val_in   = req_tdata[CMD_W +: DATA_W];
               pos_in   = req_tdata[CMD_W+DATA_W +: POS_W];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in  = STAT_OK;
            use_cap_in = 1'b0;
            state_in   = ST_LOOKUP;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     // Move elements cursor..length-1 up by one, top first.
                     cnt_in   = len_ff - cur_ff;
                     src_in   = len_ff[ADDR_W-1:0] - 1'b1;
                     state_in = ST_SHIFT_UP;
                  end
               end
               CMD_REMOVE: begin
                  if (cur_ff >= len_ff) begin
                     status_in = STAT_NOELEM;
                  end else begin
                     // Read cursor..length-1; the first read is the removed
                     // element, the rest move down by one.
                     cnt_in   = len_ff - cur_ff;
                     src_in   = cur_ff[ADDR_W-1:0];
                     state_in = ST_SHIFT_DN;
                  end
               end
               CMD_APPEND: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = len_ff[ADDR_W-1:0];
                     ram_wdata = val_ff;
                     len_in    = len_ff + 1'b1;
                  end
               end
               CMD_PREV: begin
                  if (cur_ff == '0) begin
                     status_in = STAT_RANGE;
                  end else begin
                     cur_in = cur_ff - 1'b1;
                  end
               end
               CMD_NEXT: begin
                  if (cur_ff + 1'b1 >= len_ff) begin
                     status_in = STAT_RANGE;
                  end else begin
                     cur_in = cur_ff + 1'b1;
                  end
               end
               CMD_START: begin
                  cur_in = '0;
               end
               CMD_END: begin
                  if (len_ff == '0) begin
                     cur_in    = '0;
                     status_in = STAT_RANGE;
                  end else begin
                     cur_in = len_ff - 1'b1;
                  end
               end
               CMD_GOTO: begin
                  if (COUNT_W'(pos_ff) >= len_ff) begin
                     status_in = STAT_RANGE;
                  end else begin
                     cur_in = COUNT_W'(pos_ff);
                  end
               end
               CMD_CLEAR: begin
                  len_in = '0;
                  cur_in = '0;
               end
               default: begin
               end
            endcase
         end

         ST_SHIFT_UP: begin
            if (cnt_ff != '0) begin
               ram_re       = 1'b1;
               ram_raddr    = src_ff;
               src_in       = src_ff - 1'b1;
               cnt_in       = cnt_ff - 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = src_ff;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff + 1'b1;
               ram_wdata = ram_rdata;
            end else if (cnt_ff == '0) begin
               // Gap is open: drop the new element in at the cursor.
               ram_we    = 1'b1;
               ram_waddr = cur_ff[ADDR_W-1:0];
               ram_wdata = val_ff;
               len_in    = len_ff + 1'b1;
               state_in  = ST_LOOKUP;
            end
         end

         ST_SHIFT_DN: begin
            if (cnt_ff != '0) begin
               ram_re       = 1'b1;
               ram_raddr    = src_ff;
               src_in       = src_ff + 1'b1;
               cnt_in       = cnt_ff - 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = src_ff;
            end
            if (pend_ff) begin
               if (pend_addr_ff == cur_ff[ADDR_W-1:0]) begin
                  cap_in = ram_rdata;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = pend_addr_ff - 1'b1;
                  ram_wdata = ram_rdata;
               end
            end else if (cnt_ff == '0) begin
               len_in     = len_ff - 1'b1;
               use_cap_in = 1'b1;
               state_in   = ST_DONE;
            end
         end

         ST_LOOKUP: begin
            ram_re    = 1'b1;
            ram_raddr = cur_ff[ADDR_W-1:0];
            hit_in    = (cur_ff < len_ff);
            state_in  = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cur_ff, len_ff, result_data, status_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The cursor never exceeds the list length.
   assert property (@(posedge clock) disable iff (reset) cur_ff <= len_ff)
      else $error("cursor beyond list length");

   // The length never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= COUNT_W'(CAPACITY))
      else $error("list length beyond capacity");

   // During a shift the write trails the read and never hits the same entry.
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("read and write of the same entry in one cycle");

   // An accepted request always starts at the decode step.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted request not decoded");

   // A result is loaded only from the final step of a request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_tready)) |-> (state_ff == ST_DONE))
      else $error("result loaded outside the final step");

endmodule

### sv/alwl_ram.sv
module alwl_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data is registered and holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### bench/tb_top.sv
module tb_top;
   import alwl_pkg::*;

   // Opcodes above CMD_CLEAR are not decoded by the block and must be ignored.
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_W'(CMD_CLEAR + 1);
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;

   // A long shift runs through the whole list without any handshake, and the
   // receiver may be held off on top of that. This limit leaves a wide margin.
   localparam int unsigned STALL_LIMIT   = 10000;
   localparam int unsigned BACKPRESS_LEN = 80;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned LONG_LIST_LEN = 150;

   // One result word, packed exactly as it travels on rsp_tdata (status lowest).
   typedef struct packed {
      logic [COUNT_W-1:0]       cursor;
      logic [COUNT_W-1:0]       length;
      logic signed [DATA_W-1:0] data;
      status_type               status;
   } list_report_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // cmd, value, position, zero fill above
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // status, data, length, cursor

   array_list_with_cursor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Shadow copy of the list. It is updated the moment a request is accepted,
   // so it always reflects every command the block has taken so far.
   logic [DATA_W-1:0] list_words [CAPACITY];
   int unsigned       list_len;
   int unsigned       list_cursor;

   list_report_t      pending_reports [$];
   int unsigned       fail_count;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       rsp_hold_left;
   int unsigned       stall_cycles;

   logic [DATA_W-1:0] corner_values [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0};

   // Applies one command to the shadow list and returns the report the block
   // must produce for it.
   function automatic list_report_t model_list_command(logic [CMD_W-1:0] cmd,
                                                       logic [DATA_W-1:0] value,
                                                       logic [POS_W-1:0] position);
      list_report_t rep;
      logic         removed;
      int unsigned  i;
      rep     = '0;
      removed = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            if (list_len >= CAPACITY || list_cursor > list_len) begin
               rep.status = STAT_FULL;
            end else begin
               for (i = list_len; i > list_cursor; i--) list_words[i] = list_words[i-1];
               list_words[list_cursor] = value;
               list_len++;
            end
         end
         CMD_REMOVE: begin
            if (list_cursor >= list_len) begin
               rep.status = STAT_NOELEM;
            end else begin
               rep.data = list_words[list_cursor];
               for (i = list_cursor; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
               removed = 1'b1;
            end
         end
         CMD_APPEND: begin
            if (list_len >= CAPACITY) begin
               rep.status = STAT_FULL;
            end else begin
               list_words[list_len] = value;
               list_len++;
            end
         end
         CMD_PREV: begin
            if (list_cursor == 0) rep.status = STAT_RANGE;
            else list_cursor--;
         end
         CMD_NEXT: begin
            if (list_cursor + 1 >= list_len) rep.status = STAT_RANGE;
            else list_cursor++;
         end
         CMD_START: list_cursor = 0;
         CMD_END: begin
            if (list_len == 0) begin
               list_cursor = 0;
               rep.status  = STAT_RANGE;
            end else begin
               list_cursor = list_len - 1;
            end
         end
         CMD_GOTO: begin
            if (position >= list_len) rep.status = STAT_RANGE;
            else list_cursor = position;
         end
         CMD_CLEAR: begin
            list_len    = 0;
            list_cursor = 0;
         end
         default: ;
      endcase
      if (!removed && list_cursor < list_len) rep.data = list_words[list_cursor];
      rep.length = COUNT_W'(list_len);
      rep.cursor = COUNT_W'(list_cursor);
      return rep;
   endfunction

   // Offers one request and returns once it has been accepted. It is entered
   // and left at a falling edge, so each input gets one assignment per step.
   task automatic send_list_command(logic [CMD_W-1:0] cmd,
                                    logic [DATA_W-1:0] value = '0,
                                    logic [POS_W-1:0] position = '0);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - POS_W - DATA_W - CMD_W){1'b0}}, position, value, cmd};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(model_list_command(cmd, value, position));
      @(negedge clock);
   endtask

   // Stops offering requests until every outstanding report has come back.
   task automatic drain_list_reports();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   // Empty-list corner cases, value extremes, every opcode, removing the last
   // element, the cursor sitting past the end, and ignored opcodes.
   task automatic test_basic_commands();
      send_list_command(CMD_REMOVE);
      send_list_command(CMD_PREV);
      send_list_command(CMD_NEXT);
      send_list_command(CMD_END);
      send_list_command(CMD_GOTO, '0, '0);
      send_list_command(CMD_INSERT, 32'h7FFF_FFFF);
      send_list_command(CMD_INSERT, 32'h8000_0000);
      send_list_command(CMD_APPEND, 32'hFFFF_FFFF);
      send_list_command(CMD_APPEND, 32'h0);
      send_list_command(CMD_NEXT);
      send_list_command(CMD_END);
      send_list_command(CMD_NEXT);
      send_list_command(CMD_GOTO, '0, '1);
      send_list_command(CMD_GOTO, '0, 10'd2);
      send_list_command(CMD_REMOVE);
      send_list_command(CMD_END);
      send_list_command(CMD_REMOVE);
      send_list_command(CMD_REMOVE);
      send_list_command(CMD_NEXT);
      send_list_command(CMD_INSERT, 32'hA5A5_A5A5);
      send_list_command(CMD_PREV);
      send_list_command(CMD_START);
      send_list_command(CMD_UNUSED_FIRST, 32'h5A5A_5A5A, '1);
      send_list_command(CMD_UNUSED_LAST, 32'hFFFF_FFFF, '1);
      send_list_command(CMD_CLEAR);
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // block has to hold a finished report and then stall its input.
   task automatic test_output_backpressure();
      int unsigned n;
      drain_list_reports();
      rsp_hold_left = BACKPRESS_LEN;
      for (n = 0; n < 12; n++) begin
         if (n % 3 == 0) send_list_command(CMD_APPEND, $urandom);
         else if (n % 3 == 1) send_list_command(CMD_INSERT, $urandom);
         else send_list_command(CMD_NEXT);
      end
      drain_list_reports();
   endtask

   // Builds a long list and runs the longest shifts of the run: remove and
   // insert at the head of the list.
   task automatic test_long_list();
      int unsigned n;
      send_list_command(CMD_CLEAR);
      for (n = 0; n < LONG_LIST_LEN; n++) send_list_command(CMD_APPEND, $urandom);
      send_list_command(CMD_START);
      send_list_command(CMD_REMOVE);
      send_list_command(CMD_INSERT, 32'h8000_0000);
      send_list_command(CMD_END);
      send_list_command(CMD_NEXT);
      send_list_command(CMD_GOTO, '0, '1);
      send_list_command(CMD_REMOVE);
      send_list_command(CMD_APPEND, 32'h7FFF_FFFF);
      send_list_command(CMD_PREV);
      send_list_command(CMD_CLEAR);
   endtask

   // Random commands on a list kept short so that shifts stay cheap. Ignored
   // opcodes are mixed in but do not count toward the requested number.
   task automatic run_random_commands(int unsigned count);
      int unsigned       sent;
      int unsigned       pick;
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] value;
      logic [POS_W-1:0]  position;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) cmd = CMD_INSERT;
         else if (pick < 38) cmd = CMD_REMOVE;
         else if (pick < 50) cmd = CMD_APPEND;
         else if (pick < 58) cmd = CMD_PREV;
         else if (pick < 68) cmd = CMD_NEXT;
         else if (pick < 72) cmd = CMD_START;
         else if (pick < 78) cmd = CMD_END;
         else if (pick < 92) cmd = CMD_GOTO;
         else if (pick < 95) cmd = CMD_CLEAR;
         else cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
         if ((cmd == CMD_INSERT || cmd == CMD_APPEND) && list_len >= 40) cmd = CMD_REMOVE;
         if ($urandom_range(0, 7) == 0) value = corner_values[$urandom_range(0, 3)];
         else value = $urandom;
         // Half of the goto targets are drawn from the valid range or one past it.
         if (cmd == CMD_GOTO && $urandom_range(0, 1) == 1)
            position = POS_W'($urandom_range(0, list_len));
         else
            position = POS_W'($urandom);
         send_list_command(cmd, value, position);
         if (cmd <= CMD_CLEAR) sent++;
      end
   endtask

   // Receiver: random stalls, or a counted hold-off when one has been requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Every report taken from the block is compared with the oldest prediction.
   always @(posedge clock) begin : check_reports
      list_report_t got;
      list_report_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = list_report_t'(rsp_tdata);
         if (pending_reports.size() == 0) begin
            $error("report with no request outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               fail_count++;
            end
            if (got.data !== want.data) begin
               $error("data: expected %0d, got %0d", want.data, got.data);
               fail_count++;
            end
            if (got.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, got.length);
               fail_count++;
            end
            if (got.cursor !== want.cursor) begin
               $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: the run is dead if no request or report moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      list_len      = 0;
      list_cursor   = 0;
      fail_count    = 0;
      rsp_hold_left = 0;
      stall_cycles  = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender mostly busy, receiver often stalling.
      send_idle_pct = 19;
      recv_idle_pct = 58;
      test_basic_commands();
      test_output_backpressure();
      run_random_commands(100);
      drain_list_reports();

      // Sender often idle, receiver mostly ready.
      send_idle_pct = 58;
      recv_idle_pct = 19;
      test_long_list();
      run_random_commands(100);
      drain_list_reports();

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_commands(100);
      drain_list_reports();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d reports never arrived", pending_reports.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
